/* rtl/core/kce_pkg.sv */
// Package for the k-closest-elements selector: sizes, word types,
// function and status codes and the controller state type.
// No dependencies.
`default_nettype none

package kce_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] target;
        logic [CNT_W-1:0]         count;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] element;
        logic                     last;
        logic                     status;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHRINK,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/k_closest_elements_select.sv */
// k-closest-elements selector: sorted element store in a two-read-port
// synchronous RAM, window-shrinking search and ascending word output.
// Depends on kce_pkg.
// Clear, append and no-op words complete when accepted; a bad count gives its
// error word in the cycle after acceptance. A query with n stored elements
// blocks input until its last word: the accepting cycle issues the end reads,
// then one compare a cycle per dropped element (n - k, paced by the RAM read
// latency), a check that sees the window at k, one word a cycle while the
// output is free. Synchronous active-low reset empties the store, not the RAM.
`default_nettype none

module k_closest_elements_select
    import kce_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_a, r_rd_b;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_k, n_k;
    logic signed [DATA_W-1:0] r_target, n_target;
    logic [ADDR_W-1:0]   r_first, n_first;
    logic [ADDR_W-1:0]   r_final, n_final;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out, n_out;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                in_acc;
    logic                out_free;
    logic [CNT_W-1:0]    win_size;
    logic signed [DATA_W:0] diff_lo, diff_hi;
    logic [DATA_W:0]     dist_lo, dist_hi;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign win_size = {1'b0, r_final} - {1'b0, r_first} + CNT_W'(1);

    assign diff_lo = {r_target[DATA_W-1], r_target} - {r_rd_a[DATA_W-1], r_rd_a};
    assign diff_hi = {r_rd_b[DATA_W-1], r_rd_b} - {r_target[DATA_W-1], r_target};
    assign dist_lo = diff_lo[DATA_W] ? (DATA_W+1)'(0) - diff_lo : diff_lo;
    assign dist_hi = diff_hi[DATA_W] ? (DATA_W+1)'(0) - diff_hi : diff_hi;

    assign wr_en   = in_acc && (i_in_word.func == FUNC_APPEND) && (r_cnt < CNT_W'(DEPTH));
    assign wr_addr = r_cnt[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_in_word.value;
        end
        r_rd_a <= r_mem[n_first];
        r_rd_b <= r_mem[n_final];
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_target    = r_target;
        n_first     = r_first;
        n_final     = r_final;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_word.func)
                        FUNC_CLEAR: begin
                            n_cnt = '0;
                        end
                        FUNC_APPEND: begin
                            if (r_cnt < CNT_W'(DEPTH)) begin
                                n_cnt = r_cnt + CNT_W'(1);
                            end
                        end
                        FUNC_QUERY: begin
                            if (i_in_word.count == '0 || i_in_word.count > r_cnt) begin
                                n_out_valid     = 1'b1;
                                n_out.element   = '0;
                                n_out.last      = 1'b1;
                                n_out.status    = STATUS_BAD_COUNT;
                            end else begin
                                n_k      = i_in_word.count;
                                n_target = i_in_word.target;
                                n_first  = '0;
                                n_final  = ADDR_W'(r_cnt - CNT_W'(1));
                                n_state  = ST_SHRINK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SHRINK: begin
                if (win_size > r_k) begin
                    if (dist_lo <= dist_hi) begin
                        n_final = r_final - ADDR_W'(1);
                    end else begin
                        n_first = r_first + ADDR_W'(1);
                    end
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out.element = r_rd_a;
                    n_out.last    = (r_first == r_final);
                    n_out.status  = STATUS_OK;
                    if (r_first == r_final) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_first = r_first + ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_first     <= '0;
            r_final     <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_first     <= n_first;
            r_final     <= n_final;
        end
        r_k      <= n_k;
        r_target <= n_target;
        r_out    <= n_out;
    end

endmodule

`default_nettype wire

/* rtl/core/kce_checker.sv */
// Port-level checker for k_closest_elements_select, bound into each instance of it.
// Depends on kce_pkg.
`default_nettype none

module kce_checker
    import kce_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_word  i_in_word,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_word o_out_word
);

    // output word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // error word is a single, final zero word
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == STATUS_BAD_COUNT)
            |-> o_out_word.last && (o_out_word.element == '0))
        else $error("error word not final or not zero");

    // no new input word while a query is still being emitted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last |-> !o_in_ready)
        else $error("input taken mid-query");

    // a query asking for no elements answers with an error word next cycle
    a_zero_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_word.func == FUNC_QUERY)
            && (i_in_word.count == '0)
            |=> o_out_valid && (o_out_word.status == STATUS_BAD_COUNT))
        else $error("zero count not refused");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind k_closest_elements_select kce_checker u_kce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for k_closest_elements_select: directed table, then sorted
// loads with random queries and noise words, checked against a behavioural predictor.
// Depends on kce_pkg and the k_closest_elements_select RTL.
`default_nettype none

module tb_top;
    import kce_pkg::*;

    localparam logic [1:0] FUNC_NOP = 2'd3;
    localparam logic signed [DATA_W-1:0] EL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] EL_MAX = 32'sh7fff_ffff;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 100;

    typedef struct packed {
        t_in_word  w;
        logic      typed;
        t_out_word res;
    } t_stim_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int mismatches = 0;
    int items_sent = 0;
    int cycle_count = 0;

    // predictor copy of the store
    logic signed [DATA_W-1:0] shadow_store [DEPTH];
    int                       shadow_count = 0;

    t_out_word pending_words [$];
    t_out_word got_word;
    t_out_word want_word;
    t_stim_row directed_rows [$];

    k_closest_elements_select dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch (%s): got %0d, expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        mismatches++;
    endtask

    // queue one expected output word
    task automatic pend_word(input t_out_word r);
        pending_words.insert(pending_words.size(), r);
    endtask

    task automatic add_row(input t_stim_row r);
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // output side: random back-pressure, check each accepted word
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            got_word = out_word;
            if (pending_words.size() == 0) begin
                report_mismatch("word with nothing pending", got_word.element, 0);
            end else begin
                want_word = pending_words.pop_front();
                if (got_word.element !== want_word.element)
                    report_mismatch("element", got_word.element, want_word.element);
                if (got_word.last !== want_word.last)
                    report_mismatch("last", got_word.last, want_word.last);
                if (got_word.status !== want_word.status)
                    report_mismatch("status", got_word.status, want_word.status);
            end
        end
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    function automatic t_in_word mk_word(input logic [1:0] f, input logic signed [31:0] v,
                                         input logic signed [31:0] t, input logic [6:0] k);
        t_in_word w;
        w.func   = f;
        w.value  = v;
        w.target = t;
        w.count  = k;
        return w;
    endfunction

    function automatic t_stim_row row(input logic [1:0] f, input logic signed [31:0] v,
                                      input logic signed [31:0] t, input logic [6:0] k,
                                      input logic typed, input logic signed [31:0] e,
                                      input logic l, input logic s);
        t_stim_row r;
        r.w           = mk_word(f, v, t, k);
        r.typed       = typed;
        r.res.element = e;
        r.res.last    = l;
        r.res.status  = s;
        return r;
    endfunction

    // window shrink: drop the farther end, the upper one on a tie
    task automatic predict_word(input t_in_word w, input bit keep);
        longint    tgt;
        longint    dl;
        longint    dh;
        int        lo;
        int        hi;
        t_out_word r;
        tgt = $signed(w.target);
        case (w.func)
            FUNC_CLEAR: shadow_count = 0;
            FUNC_APPEND: begin
                if (shadow_count < DEPTH) begin
                    shadow_store[shadow_count] = w.value;
                    shadow_count++;
                end
            end
            FUNC_QUERY: begin
                if (int'(w.count) == 0 || int'(w.count) > shadow_count) begin
                    r.element = '0;
                    r.last    = 1'b1;
                    r.status  = STATUS_BAD_COUNT;
                    if (keep) pend_word(r);
                end else begin
                    lo = 0;
                    hi = shadow_count - 1;
                    while (hi - lo + 1 > int'(w.count)) begin
                        dl = tgt - longint'(shadow_store[lo]);
                        dh = longint'(shadow_store[hi]) - tgt;
                        if (dl < 0) dl = -dl;
                        if (dh < 0) dh = -dh;
                        if (dl <= dh) hi--;
                        else lo++;
                    end
                    for (int i = lo; i <= hi; i++) begin
                        r.element = shadow_store[i];
                        r.last    = (i == hi);
                        r.status  = STATUS_OK;
                        if (keep) pend_word(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input t_in_word w, input logic typed, input t_out_word res);
        if ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        predict_word(w, !typed);
        if (typed) pend_word(res);
        if (w.func != FUNC_NOP) items_sent++;
    endtask

    // hold the input off until every pending word has come out
    task automatic drain;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_words.size() != 0);
    endtask

    // clear, load n sorted elements (plus overflow appends at full depth), then a few queries
    task automatic run_sequence(input int n);
        int vals [$];
        int spread;
        int k;
        int tgt;
        int v;
        spread = $urandom_range(2);
        send_word(mk_word(FUNC_CLEAR, $urandom, $urandom, 7'($urandom_range(127))),
                  1'b0, '0);
        for (int i = 0; i < n; i++) begin
            case (spread)
                0: v = $urandom_range(40) - 20;
                1: v = $urandom;
                default: v = $urandom_range(1) ? EL_MIN + $urandom_range(3)
                                               : EL_MAX - $urandom_range(3);
            endcase
            vals.insert(vals.size(), v);
        end
        vals.sort();
        foreach (vals[i])
            send_word(mk_word(FUNC_APPEND, vals[i], $urandom, 7'($urandom_range(127))),
                      1'b0, '0);
        if (n == DEPTH) begin
            repeat ($urandom_range(1, 2))
                send_word(mk_word(FUNC_APPEND, $urandom, $urandom, 0), 1'b0, '0);
        end
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(9))
                0: k = 0;
                1: k = n + 1;
                2: k = $urandom_range(127);
                3: k = n;
                default: k = $urandom_range(1, n);
            endcase
            case ($urandom_range(5))
                0: tgt = EL_MIN;
                1: tgt = EL_MAX;
                2: tgt = $urandom;
                default: tgt = vals[$urandom_range(n - 1)] + $urandom_range(6) - 3;
            endcase
            send_word(mk_word(FUNC_QUERY, $urandom, tgt, k[6:0]), 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int budget);
        int start;
        start = items_sent;
        while (items_sent - start < budget) begin
            if ($urandom_range(99) < 15)
                send_word(mk_word(2'($urandom_range(3)), $urandom, $urandom,
                                  7'($urandom_range(127))), 1'b0, '0);
            else
                run_sequence(($urandom_range(19) == 0) ? DEPTH : $urandom_range(1, 12));
        end
    endtask

    initial begin
        add_row(row(FUNC_QUERY,  0,      0,      1,   1, 0, 1, STATUS_BAD_COUNT));
        add_row(row(FUNC_QUERY,  0,      EL_MAX, 0,   1, 0, 1, STATUS_BAD_COUNT));
        add_row(row(FUNC_NOP,    -1,     -1,     127, 0, 0, 0, STATUS_OK));
        add_row(row(FUNC_APPEND, EL_MIN, 0,      0,   0, 0, 0, STATUS_OK));
        add_row(row(FUNC_APPEND, -5,     0,      0,   0, 0, 0, STATUS_OK));
        add_row(row(FUNC_APPEND, 0,      0,      0,   0, 0, 0, STATUS_OK));
        add_row(row(FUNC_APPEND, 3,      0,      0,   0, 0, 0, STATUS_OK));
        add_row(row(FUNC_APPEND, 3,      0,      0,   0, 0, 0, STATUS_OK));
        add_row(row(FUNC_APPEND, 7,      0,      0,   0, 0, 0, STATUS_OK));
        add_row(row(FUNC_APPEND, EL_MAX, 0,      0,   0, 0, 0, STATUS_OK));
        add_row(row(FUNC_QUERY,  0,      EL_MIN, 2,   0, 0, 0, STATUS_OK));
        add_row(row(FUNC_QUERY,  0,      EL_MAX, 3,   0, 0, 0, STATUS_OK));
        add_row(row(FUNC_QUERY,  0,      5,      2,   0, 0, 0, STATUS_OK));
        add_row(row(FUNC_QUERY,  0,      3,      3,   0, 0, 0, STATUS_OK));
        add_row(row(FUNC_QUERY,  0,      0,      7,   0, 0, 0, STATUS_OK));
        add_row(row(FUNC_QUERY,  0,      0,      8,   1, 0, 1, STATUS_BAD_COUNT));
        add_row(row(FUNC_QUERY,  0,      0,      127, 1, 0, 1, STATUS_BAD_COUNT));
        add_row(row(FUNC_QUERY,  0,      EL_MAX, 1,   1, EL_MAX, 1, STATUS_OK));
        add_row(row(FUNC_QUERY,  0,      EL_MIN, 1,   1, EL_MIN, 1, STATUS_OK));
        add_row(row(FUNC_CLEAR,  0,      0,      0,   0, 0, 0, STATUS_OK));
        add_row(row(FUNC_QUERY,  0,      0,      1,   1, 0, 1, STATUS_BAD_COUNT));
        add_row(row(FUNC_APPEND, 42,     0,      0,   0, 0, 0, STATUS_OK));
        add_row(row(FUNC_QUERY,  0,      -7,     1,   1, 42, 1, STATUS_OK));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle_pct = 35;
        rcv_idle_pct = 88;
        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].res);
        drain();
        run_phase(15);
        drain();

        snd_idle_pct = 88;
        rcv_idle_pct = 35;
        run_phase(15);
        drain();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_sequence(DEPTH);
        run_phase(15);
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/core/kce_pkg.sv
rtl/core/k_closest_elements_select.sv
rtl/core/kce_checker.sv
bench/tb_top.sv
